>>> src/assert_macros.svh
// assertion macros for the imu angle frame parser rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/iafp_pkg.sv
// shared types and constants of the imu angle frame parser
// no dependencies
package iafp_pkg;

   localparam int FRAME_LEN = 11;
   localparam int CNT_W     = $clog2(FRAME_LEN);

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] ANGLE_TYPE  = 8'h53;

   // raw angle bytes sit at positions 2..7 of a frame
   localparam int ANGLE_FIRST = 2;
   localparam int ANGLE_BYTES = 6;

   localparam int               ANGLE_W     = 16;
   localparam int               SCALE_W     = 15;
   localparam logic [SCALE_W-1:0] SCALE_NUM = 15'd18000;
   localparam int               SCALE_SHIFT = 15;
   localparam int               PROD_W      = ANGLE_W + SCALE_W;
   localparam int               WIDE_W      = ANGLE_W + 1;

   localparam int OFFSET_W = 11;
   localparam int LIMIT_W  = 15;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_LIMIT   = 2'd2;

   localparam logic signed [OFFSET_W-1:0] ROLL_OFFSET_RST  = 11'sd138;
   localparam logic signed [OFFSET_W-1:0] PITCH_OFFSET_RST = 11'sd213;
   localparam logic [LIMIT_W-1:0]         ROLL_LIMIT_RST   = 15'd4000;

   localparam int MID_DEPTH = 2;
   localparam int MID_PTR_W = $clog2(MID_DEPTH);
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [ANGLE_W-1:0] roll_raw;
      logic [ANGLE_W-1:0] pitch_raw;
      logic [ANGLE_W-1:0] yaw_raw;
   } raw_frame_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] yaw;
      logic                      fault;
   } result_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] roll_offset;
      logic signed [OFFSET_W-1:0] pitch_offset;
      logic [LIMIT_W-1:0]         roll_limit;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic                 halted;
      logic [OUT_CNT_W-1:0] out_count;
   } back_status_type;

endpackage

>>> src/iafp_front.sv
// front end: header hunt, byte counting and angle byte capture
// depends on iafp_pkg
module iafp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    stall,
   input  logic [7:0]              rx_byte,
   output logic                    frame_valid,
   output iafp_pkg::raw_frame_type frame
);
   import iafp_pkg::*;

   localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAME_LEN - 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       type_ff;
   logic [7:0]       angle_ff [ANGLE_BYTES];
   logic             accept;

   assign accept = push & ~stall;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (count_ff == '0) begin
            if (rx_byte == HEADER_BYTE) begin
               count_in = CNT_W'(1);
            end
         end else if (count_ff == LAST) begin
            count_in = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // fixed slots for the type byte and the six angle bytes
   always_ff @(posedge clock) begin
      if (accept && count_ff == CNT_W'(1)) begin
         type_ff <= rx_byte;
      end
      for (int i = 0; i < ANGLE_BYTES; i++) begin
         if (accept && count_ff == CNT_W'(ANGLE_FIRST + i)) begin
            angle_ff[i] <= rx_byte;
         end
      end
   end

   assign frame_valid    = accept && count_ff == LAST && type_ff == ANGLE_TYPE;
   assign frame.roll_raw  = {angle_ff[1], angle_ff[0]};
   assign frame.pitch_raw = {angle_ff[3], angle_ff[2]};
   assign frame.yaw_raw   = {angle_ff[5], angle_ff[4]};

endmodule

>>> src/iafp_queue.sv
// short queue of raw angle frames between front and back
// depends on iafp_pkg
module iafp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  iafp_pkg::raw_frame_type    push_data,
   input  logic                       pop,
   output iafp_pkg::raw_frame_type    head,
   output iafp_pkg::queue_status_type status
);
   import iafp_pkg::*;

   raw_frame_type        slot_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0] wptr_ff, rptr_ff;
   logic [MID_CNT_W-1:0] count_ff;
   logic                 do_push, do_pop;

   assign status.full  = count_ff == MID_CNT_W'(MID_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head         = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= wptr_ff + MID_PTR_W'(1);
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + MID_PTR_W'(1);
         end
         count_ff <= count_ff + MID_CNT_W'(do_push) - MID_CNT_W'(do_pop);
      end
   end

endmodule

>>> src/iafp_back.sv
// back end: angle scaling, offsets, roll limit check and result queue
// depends on iafp_pkg
module iafp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  iafp_pkg::cfg_type         cfg,
   input  logic                      frame_ready,
   input  iafp_pkg::raw_frame_type   frame,
   output logic                      frame_take,
   input  logic                      res_pop,
   output logic                      res_empty,
   output iafp_pkg::result_type      res,
   output iafp_pkg::back_status_type status
);
   import iafp_pkg::*;

   // floor(raw * 18000 / 32768) biased by +18000
   function automatic logic [ANGLE_W-1:0] scale_biased(input logic [ANGLE_W-1:0] raw);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(raw ^ {1'b1, {(ANGLE_W-1){1'b0}}}) * PROD_W'(SCALE_NUM);
      return prod[PROD_W-1:SCALE_SHIFT];
   endfunction

   localparam logic signed [WIDE_W-1:0] UNBIAS = WIDE_W'(SCALE_NUM);

   logic               s1_valid_ff;
   logic [ANGLE_W-1:0] s1_roll_ff, s1_pitch_ff, s1_yaw_ff;
   logic               halted_ff;

   logic [OUT_CNT_W:0]  inflight;
   logic signed [WIDE_W-1:0] roll_w, pitch_w, yaw_w;
   logic signed [ANGLE_W-1:0] roll_s;
   logic [ANGLE_W-1:0]  mag;
   result_type          res_in;
   logic                res_push, do_pop;

   result_type           out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wptr_ff, rptr_ff;
   logic [OUT_CNT_W-1:0] count_ff;

   // only take a frame when its result is sure to find room
   assign inflight   = {1'b0, count_ff} + (OUT_CNT_W + 1)'(s1_valid_ff);
   assign frame_take = frame_ready && inflight < (OUT_CNT_W + 1)'(OUT_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= frame_take;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_take) begin
         s1_roll_ff  <= scale_biased(frame.roll_raw);
         s1_pitch_ff <= scale_biased(frame.pitch_raw);
         s1_yaw_ff   <= scale_biased(frame.yaw_raw);
      end
   end

   always_comb begin
      roll_w  = signed'({1'b0, s1_roll_ff}) - UNBIAS
              - WIDE_W'(cfg.roll_offset);
      pitch_w = signed'({1'b0, s1_pitch_ff}) - UNBIAS
              - WIDE_W'(cfg.pitch_offset);
      yaw_w   = signed'({1'b0, s1_yaw_ff}) - UNBIAS;
      roll_s  = roll_w[ANGLE_W-1:0];
      mag     = roll_s[ANGLE_W-1] ? ANGLE_W'(-roll_s) : ANGLE_W'(roll_s);
      res_in.roll  = roll_w[ANGLE_W-1:0];
      res_in.pitch = pitch_w[ANGLE_W-1:0];
      res_in.yaw   = yaw_w[ANGLE_W-1:0];
      res_in.fault = mag >= ANGLE_W'(cfg.roll_limit);
   end

   // once halted every later frame is dropped
   assign res_push = s1_valid_ff & ~halted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else if (res_push && res_in.fault) begin
         halted_ff <= 1'b1;
      end
   end

   assign res_empty = count_ff == '0;
   assign do_pop    = res_pop & ~res_empty;
   assign res       = out_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (res_push) begin
         out_ff[wptr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (res_push) begin
            wptr_ff <= wptr_ff + OUT_PTR_W'(1);
         end
         if (do_pop) begin
            rptr_ff <= rptr_ff + OUT_PTR_W'(1);
         end
         count_ff <= count_ff + OUT_CNT_W'(res_push) - OUT_CNT_W'(do_pop);
      end
   end

   assign status.halted    = halted_ff;
   assign status.out_count = count_ff;

endmodule

>>> src/imu_angle_frame_parser.sv
// imu angle frame parser, top level
// depends on iafp_pkg, iafp_front, iafp_queue, iafp_back and assert_macros.svh
//
// usage:
// - byte channel: push a serial byte on req_rx_byte with req_push; a beat is taken
//   at a clock edge with req_push high and req_full low. one byte per cycle while req_full is low.
// - bytes outside a frame other than the 0x55 header are dropped; from the header
//   on, 11-byte frames are gathered. an angle frame (type 0x53) yields one result
//   beat; other frame types yield nothing. the checksum is not checked.
// - result channel: while rsp_empty is low the oldest result is on rsp_roll,
//   rsp_pitch, rsp_yaw and rsp_fault; rsp_pop high takes it.
// - path: the frame queue is written at the edge that takes the frame's last byte;
//   the frame then passes the multiplier stage and is written to the result queue.
// - throughput: one byte per cycle; the front frame queue and a four-entry result
//   queue let bytes keep flowing while the receiver stalls. req_full rises only
//   when results back up through both queues.
// - fault: when |roll| reaches roll_limit the result carries rsp_fault = 1 and the
//   block halts; later bytes are taken and discarded until reset.
// - csr: csr_we writes csr_wdata to register csr_index (0 roll offset, 1 pitch
//   offset, 2 roll limit) at once; write only while idle.
// - reset: synchronous, clears frame state, queues and the fault; registers go to
//   138, 213 and 4000. no clearing pass.
`include "assert_macros.svh"

module imu_angle_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [iafp_pkg::ANGLE_W-1:0] rsp_roll,
   output logic signed [iafp_pkg::ANGLE_W-1:0] rsp_pitch,
   output logic signed [iafp_pkg::ANGLE_W-1:0] rsp_yaw,
   output logic                                rsp_fault,
   input  logic                                csr_we,
   input  logic [iafp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [iafp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import iafp_pkg::*;

   // configuration registers
   logic signed [OFFSET_W-1:0] roll_offset_ff;
   logic signed [OFFSET_W-1:0] pitch_offset_ff;
   logic [LIMIT_W-1:0]         roll_limit_ff;
   cfg_type                    cfg;

   // front to queue
   logic             frame_valid;
   raw_frame_type    front_frame;

   // queue to back
   raw_frame_type    mid_head;
   queue_status_type mid_status;
   logic             frame_take;

   // back status and result head
   back_status_type  back_status;
   result_type       res;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_offset_ff  <= ROLL_OFFSET_RST;
         pitch_offset_ff <= PITCH_OFFSET_RST;
         roll_limit_ff   <= ROLL_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROLL_OFFSET: begin
               roll_offset_ff <= csr_wdata[OFFSET_W-1:0];
            end
            CSR_PITCH_OFFSET: begin
               pitch_offset_ff <= csr_wdata[OFFSET_W-1:0];
            end
            CSR_ROLL_LIMIT: begin
               roll_limit_ff <= csr_wdata[LIMIT_W-1:0];
            end
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   assign cfg.roll_offset  = roll_offset_ff;
   assign cfg.pitch_offset = pitch_offset_ff;
   assign cfg.roll_limit   = roll_limit_ff;

   // byte beats stall only when the frame queue is full
   assign req_full = mid_status.full;

   iafp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .stall       (mid_status.full),
      .rx_byte     (req_rx_byte),
      .frame_valid (frame_valid),
      .frame       (front_frame)
   );

   iafp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_valid),
      .push_data (front_frame),
      .pop       (frame_take),
      .head      (mid_head),
      .status    (mid_status)
   );

   iafp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .frame_ready (~mid_status.empty),
      .frame       (mid_head),
      .frame_take  (frame_take),
      .res_pop     (rsp_pop),
      .res_empty   (rsp_empty),
      .res         (res),
      .status      (back_status)
   );

   assign rsp_roll  = res.roll;
   assign rsp_pitch = res.pitch;
   assign rsp_yaw   = res.yaw;
   assign rsp_fault = res.fault;

   // a fault result is the last one ever queued
   `ASSERT_NEXT(a_fault_last, clock, reset, rsp_pop && !rsp_empty && rsp_fault, rsp_empty, "result after fault")
   // halt is sticky until reset
   `ASSERT_NEXT(a_halt_sticky, clock, reset, back_status.halted, back_status.halted, "halt dropped")
   // the front never completes a frame into a full queue
   `ASSERT_ALWAYS(a_mid_no_overflow, clock, reset, !(frame_valid && mid_status.full), "frame queue overflow")
   // result queue credit keeps its count within depth
   `ASSERT_ALWAYS(a_out_bound, clock, reset, back_status.out_count <= OUT_CNT_W'(OUT_DEPTH), "result queue overflow")

endmodule
